[rtl/core/idll_pkg.sv]
// idll_pkg: shared constants, codes and types for the reorderable linked list
// no dependencies
package idll_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS + 1);
  localparam int CNT_W     = 11;
  localparam int SUM_W     = 20;
  localparam int MODE_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEFORE  = 3'd0,
    MODE_AFTER   = 3'd1,
    MODE_SWAP    = 3'd2,
    MODE_REVERSE = 3'd3,
    MODE_REPORT  = 3'd4,
    MODE_REBUILD = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_RD_Y,
    S_RD_X,
    S_PLAN,
    S_WR,
    S_REP_START,
    S_REP_WALK,
    S_REP_DONE
  } state_t;

endpackage

[rtl/core/idll_ifs.sv]
// idll_ifs: valid/ready channel interfaces for command, result and count write
// depends on idll_pkg
interface idll_in_if import idll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CNT_W-1:0]  item_x;
  logic [CNT_W-1:0]  item_y;
  modport source (output valid, mode, item_x, item_y, input ready);
  modport sink   (input valid, mode, item_x, item_y, output ready);
endinterface

interface idll_out_if import idll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] odd_position_sum;
  modport source (output valid, odd_position_sum, input ready);
  modport sink   (input valid, odd_position_sum, output ready);
endinterface

interface idll_cfg_if import idll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] item_count;
  modport source (output valid, item_count, input ready);
  modport sink   (input valid, item_count, output ready);
endinterface

[rtl/core/indexed_doubly_linked_list_reorder_top.sv]
// indexed_doubly_linked_list_reorder_top: circular linked list of items with
// lazy reversal, move/swap/reverse/report/rebuild commands; uses idll_pkg, idll_ifs, idll_ram
//
// channel   dir  payload                         transfer when
// in_ch     in   mode, item_x, item_y            valid & ready
// out_ch    out  odd_position_sum                valid & ready
// cfg_ch    in   item_count                      valid & ready (always ready)
//
// one command at a time; prev and next tables each have a single read port, driven by a shared read address.
// move or swap: read y, read x, plan, then one link pair written a cycle
// reverse: flag toggled on acceptance; report: one link hop per cycle through the ring
// rebuild: ring refilled over indices 0..item_count, one index written in both tables per cycle
// after reset a ring-fill pass over indices 0..MAX_ITEMS runs before in_ch is ready
// a finished report waits in the output register; only the next report stalls
module indexed_doubly_linked_list_reorder_top import idll_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  idll_in_if.sink     in_ch,
  idll_out_if.source  out_ch,
  idll_cfg_if.sink    cfg_ch
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic              rev_r;
  logic [IDX_W-1:0]  sweep_n_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  step_r;
  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  x_r, y_r;
  logic [IDX_W-1:0]  py_r, ny_r;
  logic [IDX_W-1:0]  jl_r [4];
  logic [IDX_W-1:0]  jr_r [4];
  logic [2:0]        njoin_r;
  logic [1:0]        j_r;
  logic [SUM_W-1:0]  odd_r, all_r;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;

  logic              acc;
  logic              ok_range;
  logic              prev_we, next_we;
  logic [IDX_W-1:0]  prev_wa, next_wa, prev_wd, next_wd, raddr;
  logic [IDX_W-1:0]  rd_prev, rd_next;
  logic [IDX_W-1:0]  pl_l [4];
  logic [IDX_W-1:0]  pl_r [4];
  logic [2:0]        pl_n;
  logic [SUM_W-1:0]  rep_final;
  logic [CNT_W-1:0]  cfg_v;

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.odd_position_sum = out_sum_r;

  // operands present, distinct and inside the current count
  assign ok_range = (in_ch.item_x != in_ch.item_y) && (in_ch.item_x != '0) &&
                    (in_ch.item_y != '0) && (in_ch.item_x <= count_r) &&
                    (in_ch.item_y <= count_r);

  // link tables
  idll_ram #(.DEPTH(MAX_ITEMS + 1), .WIDTH(IDX_W)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(raddr), .rdata(rd_prev)
  );
  idll_ram #(.DEPTH(MAX_ITEMS + 1), .WIDTH(IDX_W)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(raddr), .rdata(rd_next)
  );

  // relink plan from the fetched neighbors of x (read data) and y (held)
  always_comb begin
    logic          sw;
    logic [IDX_W-1:0] a, b, la, ra, lb, rb;
    sw = (ny_r == x_r);
    a  = sw ? y_r : x_r;
    b  = sw ? x_r : y_r;
    la = sw ? py_r : rd_prev;
    ra = sw ? ny_r : rd_next;
    lb = sw ? rd_prev : py_r;
    rb = sw ? rd_next : ny_r;
    for (int k = 0; k < 4; k++) begin
      pl_l[k] = '0;
      pl_r[k] = '0;
    end
    pl_n = 3'd0;
    unique case (mode_r)
      MODE_SWAP: begin
        pl_l[0] = la; pl_r[0] = b;
        if (ra == b) begin
          pl_l[1] = b; pl_r[1] = a;
          pl_l[2] = a; pl_r[2] = rb;
          pl_n = 3'd3;
        end else begin
          pl_l[1] = b;  pl_r[1] = ra;
          pl_l[2] = lb; pl_r[2] = a;
          pl_l[3] = a;  pl_r[3] = rb;
          pl_n = 3'd4;
        end
      end
      MODE_BEFORE: begin
        pl_l[0] = rd_prev; pl_r[0] = rd_next;
        pl_l[1] = py_r;    pl_r[1] = x_r;
        pl_l[2] = x_r;     pl_r[2] = y_r;
        pl_n = (py_r == x_r) ? 3'd0 : 3'd3;
      end
      MODE_AFTER: begin
        pl_l[0] = rd_prev; pl_r[0] = rd_next;
        pl_l[1] = y_r;     pl_r[1] = x_r;
        pl_l[2] = x_r;     pl_r[2] = ny_r;
        pl_n = (ny_r == x_r) ? 3'd0 : 3'd3;
      end
      default: pl_n = 3'd0;
    endcase
  end

  assign rep_final = (rev_r && !count_r[0]) ? (all_r - odd_r) : odd_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: next state and table port control
  always_comb begin
    state_nxt = state_r;
    prev_we = 1'b0;
    next_we = 1'b0;
    prev_wa = '0;
    next_wa = '0;
    prev_wd = '0;
    next_wd = '0;
    raddr   = '0;
    unique case (state_r)
      S_SWEEP: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        prev_wa = idx_r;
        next_wa = idx_r;
        prev_wd = (idx_r == '0) ? sweep_n_r : idx_r - 1'b1;
        next_wd = (idx_r == sweep_n_r) ? '0 : idx_r + 1'b1;
        if (idx_r == sweep_n_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          priority case (in_ch.mode)
            MODE_BEFORE, MODE_AFTER, MODE_SWAP: begin
              if (ok_range) state_nxt = S_RD_Y;
            end
            MODE_REPORT:  state_nxt = S_REP_START;
            MODE_REBUILD: state_nxt = S_SWEEP;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_Y: begin
        raddr     = y_r;
        state_nxt = S_RD_X;
      end
      S_RD_X: begin
        raddr     = x_r;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        state_nxt = (pl_n == 3'd0) ? S_IDLE : S_WR;
      end
      S_WR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = jl_r[j_r];
        next_wd = jr_r[j_r];
        prev_wa = jr_r[j_r];
        prev_wd = jl_r[j_r];
        if (3'(j_r) + 3'd1 == njoin_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_REP_START: begin
        raddr     = '0;
        state_nxt = S_REP_WALK;
      end
      S_REP_WALK: begin
        raddr = rd_next;
        if (step_r == count_r) begin
          state_nxt = S_REP_DONE;
        end
      end
      S_REP_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // count register write, clamped into one..MAX_ITEMS
  always_comb begin
    if (cfg_ch.item_count == '0) begin
      cfg_v = CNT_W'(1);
    end else if (32'(cfg_ch.item_count) > MAX_ITEMS) begin
      cfg_v = CNT_W'(MAX_ITEMS);
    end else begin
      cfg_v = cfg_ch.item_count;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(MAX_ITEMS < 1024 ? MAX_ITEMS : 1024);
      rev_r       <= 1'b0;
      sweep_n_r   <= IDX_W'(MAX_ITEMS);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      njoin_r     <= '0;
      step_r      <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_r <= cfg_v;
      end
      // result register: load on report finish, clear on transfer
      if (state_r == S_REP_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          idx_r <= idx_r + 1'b1;
          rev_r <= 1'b0;
        end
        S_IDLE: begin
          idx_r <= '0;
          j_r   <= '0;
          step_r <= CNT_W'(1);
          if (acc && in_ch.mode == MODE_REVERSE) begin
            rev_r <= !rev_r;
          end
          if (acc && in_ch.mode == MODE_REBUILD) begin
            sweep_n_r <= IDX_W'(count_r);
          end
        end
        S_PLAN: njoin_r <= pl_n;
        S_WR: j_r <= j_r + 1'b1;
        S_REP_WALK: step_r <= step_r + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      x_r    <= IDX_W'(in_ch.item_x);
      y_r    <= IDX_W'(in_ch.item_y);
      // lazy reversal swaps the sense of before and after
      mode_r <= (rev_r && (in_ch.mode == MODE_BEFORE || in_ch.mode == MODE_AFTER)) ?
                (in_ch.mode ^ MODE_W'(1)) : in_ch.mode;
      odd_r <= '0;
      all_r <= '0;
    end
    if (state_r == S_RD_X) begin
      py_r <= rd_prev;
      ny_r <= rd_next;
    end
    if (state_r == S_PLAN) begin
      for (int k = 0; k < 4; k++) begin
        jl_r[k] <= pl_l[k];
        jr_r[k] <= pl_r[k];
      end
    end
    if (state_r == S_REP_WALK) begin
      all_r <= all_r + SUM_W'(rd_next);
      if (step_r[0]) begin
        odd_r <= odd_r + SUM_W'(rd_next);
      end
    end
    if (state_r == S_REP_DONE && (!out_valid_r || out_ch.ready)) begin
      out_sum_r <= rep_final;
    end
  end

`ifndef SYNTHESIS
  // a result appears only out of the report finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_REP_DONE))
    else $error("result raised outside report finish");

  // reversal flag moves only on a reverse command or a rebuild pass
  a_rev_src: assert property (@(posedge clk) disable iff (!rst_n)
    (rev_r != $past(rev_r)) |->
      ($past(acc && in_ch.mode == MODE_REVERSE) || $past(state_r == S_SWEEP)))
    else $error("reversal flag changed unexpectedly");

  // fill pass stays within the ring being built
  a_sweep_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (idx_r <= sweep_n_r))
    else $error("fill index past ring end");
`endif

endmodule

[rtl/core/idll_ram.sv]
// idll_ram: single write port, single read port memory with registered read
// no dependencies
module idll_ram #(
  parameter int DEPTH = 1025,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
